// ----- rtl/core/moving_average_ema_filter_defines.svh -----
// Assertion macros used by the port-level checker of the range smoother.
// Every macro expects signals named clk and rst in the scope where it is used.
`ifndef MOVING_AVERAGE_EMA_FILTER_DEFINES_SVH
`define MOVING_AVERAGE_EMA_FILTER_DEFINES_SVH

// A word that is offered and stalled is offered again on the next cycle.
`define MAE_ASSERT_HOLD(label, vld, stl) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (vld && stl) |=> vld) else $error("valid dropped while stalled");

// The payload of a stalled word does not change.
`define MAE_ASSERT_STABLE(label, vld, stl, data) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (vld && stl) |=> $stable(data)) else $error("payload changed while stalled");

// General implication, checked on every clock edge outside reset.
`define MAE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (ante) |-> (cons)) else $error("implication failed");

`endif

// ----- rtl/core/mae_pkg.sv -----
// Shared constants for the range smoother: sample format, window length,
// reciprocal for the average and the output queue size. No dependencies.
`default_nettype none

package mae_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned WINDOW_LEN  = 10;
  localparam int unsigned GAIN_BITS   = 8;

  localparam int unsigned PTR_BITS = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_LEN);

  localparam logic [GAIN_BITS-1:0]   GAIN_RESET = GAIN_BITS'(64);
  localparam logic [SAMPLE_BITS-1:0] FILL_VALUE = SAMPLE_BITS'(3) << (SAMPLE_BITS - 4);
  localparam logic [SUM_BITS-1:0]    SUM_RESET  =
    SUM_BITS'(FILL_VALUE) * SUM_BITS'(WINDOW_LEN);

  // Average = floor(sum / WINDOW_LEN) = (sum * RECIP) >> RECIP_SHIFT, exact for every
  // SUM_BITS-wide sum because RECIP is rounded up with $clog2(WINDOW_LEN) spare bits.
  localparam int unsigned RECIP_SHIFT = SUM_BITS + $clog2(WINDOW_LEN);
  localparam int unsigned RECIP_BITS  = SUM_BITS + 1;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam int unsigned PROD_BITS = SUM_BITS + RECIP_BITS;

  localparam int unsigned QDEPTH    = 8;
  localparam int unsigned QPTR_BITS = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS = $clog2(QDEPTH + 1);

endpackage

`default_nettype wire

// ----- rtl/core/mae_out_queue.sv -----
// Small output queue of smoothed words with a valid/stall read side.
// Depends on mae_pkg for the word width and queue depth.
`default_nettype none

module mae_out_queue (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire logic [mae_pkg::SAMPLE_BITS-1:0] push_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [mae_pkg::SAMPLE_BITS-1:0]      out_data,
  output logic [mae_pkg::QCNT_BITS-1:0]        level
);
  import mae_pkg::*;

  logic [SAMPLE_BITS-1:0] slots [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic                   pop;

  assign out_valid = (level != '0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // The producer never pushes into a full queue; it reserves space on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + QCNT_BITS'(1);
        2'b01:   level <= level - QCNT_BITS'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/moving_average_ema_filter.sv -----
// Range smoother: ten-sample moving average in a window memory, then a
// first-order low-pass. Depends on mae_pkg and mae_out_queue.
//
//   channel   direction  handshake                      payload
//   sample    in         sample_valid / sample_stall    sample[15:0]
//   smoothed  out        smoothed_valid / smoothed_stall smoothed[15:0]
//   gain      in         gain_we                        gain_wdata[7:0]
//
// One sample per cycle is taken while sample_stall is low. The stages are
// window read, running-sum update, reciprocal multiply, filter step.
// Throughput is set by the sum and filter feedback loops. sample_stall is
// high during reset and when the output queue plus the words in flight
// would fill it. Reset is synchronous.
`default_nettype none

module moving_average_ema_filter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            sample_valid,
  output logic                                 sample_stall,
  input  wire logic [mae_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                 smoothed_valid,
  input  wire logic                            smoothed_stall,
  output logic [mae_pkg::SAMPLE_BITS-1:0]      smoothed,
  input  wire logic                            gain_we,
  input  wire logic [mae_pkg::GAIN_BITS-1:0]   gain_wdata
);
  import mae_pkg::*;

  logic [GAIN_BITS-1:0]   gain;

  // Window memory with a registered read; filled flags stand in for the 3.0 m preset.
  logic [SAMPLE_BITS-1:0] win_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]  filled;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [PTR_BITS-1:0]    ptr;

  logic                   accept;
  logic                   v1;
  logic                   v2;
  logic                   v3;
  logic [SAMPLE_BITS-1:0] s1;
  logic [PTR_BITS-1:0]    ptr1;
  logic [SAMPLE_BITS-1:0] old1;
  logic [SUM_BITS-1:0]    sum;
  logic [SUM_BITS-1:0]    sum_next;
  logic [PROD_BITS-1:0]   prod2;
  logic [SAMPLE_BITS-1:0] avg3;
  logic [SAMPLE_BITS-1:0] cur;
  logic [SAMPLE_BITS-1:0] cur_next;
  logic [SAMPLE_BITS-1:0] delta;
  logic [SAMPLE_BITS+GAIN_BITS:0] step_raw;
  logic [SAMPLE_BITS-1:0] step;
  logic                   rising;

  logic [QCNT_BITS-1:0]   level;
  logic [QCNT_BITS+1:0]   committed;

  // Every accepted word already owns a queue slot when it arrives there.
  assign committed = (QCNT_BITS+2)'(level) + (QCNT_BITS+2)'(v1)
                   + (QCNT_BITS+2)'(v2) + (QCNT_BITS+2)'(v3);
  assign sample_stall = rst || (committed >= (QCNT_BITS+2)'(QDEPTH));
  assign accept = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (gain_we) begin
      gain <= gain_wdata;
    end
  end

  // The entry read for a sample is written back in the following cycle; the next read
  // of that entry is a full window away, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= win_mem[ptr];
    end
    if (v1) begin
      win_mem[ptr1] <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1   <= sample;
      ptr1 <= ptr;
    end
    prod2 <= PROD_BITS'(sum) * PROD_BITS'(RECIP);
  end

  // The product register already holds the sum of the word in the filter stage.
  assign avg3 = SAMPLE_BITS'(prod2 >> RECIP_SHIFT);

  assign old1     = filled[ptr1] ? rd_data : FILL_VALUE;
  assign sum_next = sum - SUM_BITS'(old1) + SUM_BITS'(s1);

  // Low-pass step, floored in both directions.
  always_comb begin
    rising   = (avg3 >= cur);
    delta    = rising ? (avg3 - cur) : (cur - avg3);
    step_raw = (SAMPLE_BITS+GAIN_BITS+1)'(delta) * (SAMPLE_BITS+GAIN_BITS+1)'(gain);
    if (!rising) begin
      step_raw = step_raw + (SAMPLE_BITS+GAIN_BITS+1)'(2**GAIN_BITS - 1);
    end
    step     = SAMPLE_BITS'(step_raw >> GAIN_BITS);
    cur_next = rising ? (cur + step) : (cur - step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      filled <= '0;
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      sum    <= SUM_RESET;
      cur    <= '0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      if (accept) begin
        ptr <= (ptr == PTR_BITS'(WINDOW_LEN - 1)) ? '0 : ptr + PTR_BITS'(1);
      end
      if (v1) begin
        sum          <= sum_next;
        filled[ptr1] <= 1'b1;
      end
      if (v3) begin
        cur <= cur_next;
      end
    end
  end

  mae_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (v3),
    .push_data (cur_next),
    .out_valid (smoothed_valid),
    .out_stall (smoothed_stall),
    .out_data  (smoothed),
    .level     (level)
  );

endmodule

`default_nettype wire

// ----- rtl/core/mae_checker.sv -----
// Port-level checks for the range smoother, bound to the top level.
// Depends on the assertion macros in moving_average_ema_filter_defines.svh.
`default_nettype none
`include "moving_average_ema_filter_defines.svh"

module mae_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            sample_valid,
  input wire logic                            sample_stall,
  input wire logic                            smoothed_valid,
  input wire logic                            smoothed_stall,
  input wire logic [mae_pkg::SAMPLE_BITS-1:0] smoothed
);

  logic       in_acc;
  logic [3:0] acc_hist;

  assign in_acc = sample_valid && !sample_stall;

  // Four-bit history of accepts, newest in bit 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_hist <= '0;
    end else begin
      acc_hist <= {acc_hist[2:0], in_acc};
    end
  end

  `MAE_ASSERT_HOLD(out_hold, smoothed_valid, smoothed_stall)
  `MAE_ASSERT_STABLE(out_stable, smoothed_valid, smoothed_stall, smoothed)
  // Nothing is offered right after reset is released.
  `MAE_ASSERT_IMPLY(idle_after_reset, $past(rst), !smoothed_valid)
  // A new word needs an accepted sample that is still in the accept history.
  `MAE_ASSERT_IMPLY(no_spurious_word, !$past(smoothed_valid) && (acc_hist == '0), !smoothed_valid)

endmodule

bind moving_average_ema_filter mae_checker u_mae_checker (
  .clk            (clk),
  .rst            (rst),
  .sample_valid   (sample_valid),
  .sample_stall   (sample_stall),
  .smoothed_valid (smoothed_valid),
  .smoothed_stall (smoothed_stall),
  .smoothed       (smoothed)
);

`default_nettype wire

// ----- tb/moving_average_ema_filter_test.sv -----
// Self-checking testbench for the range smoother: a ten-sample moving average
// followed by a first-order low-pass with a programmable Q0.8 gain.
// Depends on mae_pkg and the moving_average_ema_filter RTL.
module moving_average_ema_filter_test;

  import mae_pkg::*;

  localparam int unsigned SW  = SAMPLE_BITS;
  localparam int unsigned WIN = WINDOW_LEN;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          sample_valid = 1'b0;
  logic          sample_stall;
  logic [SW-1:0] sample = '0;
  logic          smoothed_valid;
  logic          smoothed_stall = 1'b0;
  logic [SW-1:0] smoothed;
  logic          gain_we = 1'b0;
  logic [GAIN_BITS-1:0] gain_wdata = '0;

  // Local copy of the filter state used to predict each smoothed word.
  logic [SW-1:0]        win_samples [WIN];
  int unsigned          win_head;
  logic [31:0]          win_total;
  logic [SW-1:0]        lp_level;
  logic [GAIN_BITS-1:0] gain_q08;

  logic [SW-1:0] smoothed_due [$];
  logic [SW-1:0] due_word;
  int unsigned   mismatch_count = 0;
  int unsigned   send_idle_pct = 12;
  int unsigned   stall_pct = 45;
  logic [SW-1:0] hold_level = FILL_VALUE;

  moving_average_ema_filter u_top (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample         (sample),
    .smoothed_valid (smoothed_valid),
    .smoothed_stall (smoothed_stall),
    .smoothed       (smoothed),
    .gain_we        (gain_we),
    .gain_wdata     (gain_wdata)
  );

  always #2 clk = ~clk;

  function automatic logic [SW-1:0] predict_smoothed(input logic [SW-1:0] s);
    logic [31:0] avg;
    logic [31:0] diff;
    win_total = win_total - win_samples[win_head] + s;
    win_samples[win_head] = s;
    win_head = (win_head == WIN - 1) ? 0 : win_head + 1;
    avg = win_total / WIN;
    // The filter step is floored in both directions, so a falling step rounds up
    // its magnitude.
    if (avg >= lp_level) begin
      diff = avg - lp_level;
      lp_level = lp_level + SW'((gain_q08 * diff) >> 8);
    end else begin
      diff = lp_level - avg;
      lp_level = lp_level - SW'((gain_q08 * diff + 255) >> 8);
    end
    return lp_level;
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    logic [SW-1:0] noise;
    if ($urandom_range(0, 19) == 0) begin
      hold_level = SW'($urandom_range(0, 65535));
    end
    noise = SW'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0, 1: return SW'($urandom_range(0, 65535));
      2: return ($urandom_range(0, 1) == 0) ? '0 : '1;
      3: return ($urandom_range(0, 1) == 0) ? noise : ~noise;
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          return (hold_level > {SW{1'b1}} - noise) ? '1 : hold_level + noise;
        end
        return (hold_level < noise) ? '0 : hold_level - noise;
      end
    endcase
  endfunction

  // Drop valid for a random number of cycles, then offer the word until it is
  // taken. Valid is left high on return so back-to-back words need no bubble.
  task automatic send_sample(input logic [SW-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (sample_stall);
    smoothed_due.insert(smoothed_due.size(), predict_smoothed(value));
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (smoothed_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_BITS-1:0] g);
    wait_drained();
    gain_we <= 1'b1;
    gain_wdata <= g;
    @(posedge clk);
    gain_we <= 1'b0;
    gain_q08 = g;
  endtask

  task automatic test_reset_defaults();
    repeat (3) send_sample(FILL_VALUE);
  endtask

  // Full-scale steps up and down at the reset gain exercise both rounding
  // directions and large window sums.
  task automatic test_full_scale_steps();
    repeat (8) send_sample('1);
    repeat (8) send_sample('0);
  endtask

  task automatic test_gain_extremes();
    write_gain('1);
    repeat (3) send_sample('1);
    write_gain('0);
    repeat (3) send_sample('0);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_percent,
                                     input int unsigned count);
    send_idle_pct = idle_pct;
    stall_pct = stall_percent;
    for (int seg = 0; seg < 5; seg++) begin
      case ($urandom_range(0, 4))
        0: write_gain('0);
        1: write_gain('1);
        2: write_gain(GAIN_RESET);
        default: write_gain(GAIN_BITS'($urandom_range(0, 255)));
      endcase
      repeat (count / 5) send_sample(pick_sample());
    end
  endtask

  always @(posedge clk) begin
    smoothed_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && smoothed_valid && !smoothed_stall) begin
      if (smoothed_due.size() == 0) begin
        $error("smoothed: no word expected, actual %0d", smoothed);
        mismatch_count++;
      end else begin
        due_word = smoothed_due.pop_front();
        if (smoothed !== due_word) begin
          $error("smoothed: expected %0d, actual %0d", due_word, smoothed);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < WIN; i++) win_samples[i] = FILL_VALUE;
    win_head = 0;
    win_total = 32'(SUM_RESET);
    lp_level = '0;
    gain_q08 = GAIN_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_full_scale_steps();
    test_gain_extremes();
    test_random_traffic(12, 45, 600);
    test_random_traffic(45, 12, 600);
    test_random_traffic(0, 0, 625);
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("moving_average_ema_filter_test: done, clean");
    end else begin
      $display("moving_average_ema_filter_test: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("moving_average_ema_filter_test: done, errors");
    $finish;
  end

endmodule
